>>> design/mqtt_packet_byte_parser_core_macros.svh
// ----------------------------------------------------------------------------
// MQTT packet byte parser assertion macros
// Shared assertion wrappers. Defining ASSERT_OFF turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef MQTT_PACKET_BYTE_PARSER_CORE_MACROS_SVH
`define MQTT_PACKET_BYTE_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define MPBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MPBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MPBP_ASSERT(lbl, prop, msg)
`define MPBP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> design/mpbp_pkg.sv
// ----------------------------------------------------------------------------
// MQTT packet byte parser package
// Widths, byte role and error codes, and the parse phase type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpbp_pkg;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int ROLE_W  = 4;
    localparam int VALUE_W = 28;
    localparam int TYPE_W  = 4;
    localparam int QOS_W   = 2;
    localparam int ERR_W   = 2;
    localparam int COUNT_W = 16;
    localparam int LBC_W   = 2;

    // Longest allowed remaining length encoding, in bytes.
    localparam int MAX_LENGTH_BYTES = 4;

    // Control packet types that get a parsed body.
    localparam logic [TYPE_W-1:0] TYPE_CONNECT     = 4'd1;
    localparam logic [TYPE_W-1:0] TYPE_PUBLISH     = 4'd3;
    localparam logic [TYPE_W-1:0] TYPE_SUBSCRIBE   = 4'd8;
    localparam logic [TYPE_W-1:0] TYPE_UNSUBSCRIBE = 4'd10;

    // Byte roles.
    localparam logic [ROLE_W-1:0] ROLE_HEADER    = 4'd0;
    localparam logic [ROLE_W-1:0] ROLE_LEN_BYTE  = 4'd1;
    localparam logic [ROLE_W-1:0] ROLE_LEN_DONE  = 4'd2;
    localparam logic [ROLE_W-1:0] ROLE_HIGH_HALF = 4'd3;
    localparam logic [ROLE_W-1:0] ROLE_NAME_LEN  = 4'd4;
    localparam logic [ROLE_W-1:0] ROLE_NAME_BYTE = 4'd5;
    localparam logic [ROLE_W-1:0] ROLE_VERSION   = 4'd6;
    localparam logic [ROLE_W-1:0] ROLE_CON_FLAGS = 4'd7;
    localparam logic [ROLE_W-1:0] ROLE_KEEPALIVE = 4'd8;
    localparam logic [ROLE_W-1:0] ROLE_ID_LEN    = 4'd9;
    localparam logic [ROLE_W-1:0] ROLE_ID_BYTE   = 4'd10;
    localparam logic [ROLE_W-1:0] ROLE_PACKET_ID = 4'd11;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD   = 4'd12;
    localparam logic [ROLE_W-1:0] ROLE_SUB_QOS   = 4'd13;
    localparam logic [ROLE_W-1:0] ROLE_OPAQUE    = 4'd14;
    localparam logic [ROLE_W-1:0] ROLE_SKIPPED   = 4'd15;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_LEN   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [ERR_W-1:0] ERR_CON_LEN   = 2'd3;

    // Parse phases, one-hot.
    typedef enum logic [25:0] {
        PH_HDR       = 26'h0000001,
        PH_LEN       = 26'h0000002,
        PH_SKIP      = 26'h0000004,
        PH_OPAQUE    = 26'h0000008,
        PH_C_NLEN_H  = 26'h0000010,
        PH_C_NLEN_L  = 26'h0000020,
        PH_C_NAME    = 26'h0000040,
        PH_C_VER     = 26'h0000080,
        PH_C_FLAGS   = 26'h0000100,
        PH_C_KA_H    = 26'h0000200,
        PH_C_KA_L    = 26'h0000400,
        PH_C_IDLEN_H = 26'h0000800,
        PH_C_IDLEN_L = 26'h0001000,
        PH_C_ID      = 26'h0002000,
        PH_P_TLEN_H  = 26'h0004000,
        PH_P_TLEN_L  = 26'h0008000,
        PH_P_TOPIC   = 26'h0010000,
        PH_P_ID_H    = 26'h0020000,
        PH_P_ID_L    = 26'h0040000,
        PH_P_PAY     = 26'h0080000,
        PH_S_ID_H    = 26'h0100000,
        PH_S_ID_L    = 26'h0200000,
        PH_S_TLEN_H  = 26'h0400000,
        PH_S_TLEN_L  = 26'h0800000,
        PH_S_TOPIC   = 26'h1000000,
        PH_S_QOS     = 26'h2000000
    } t_phase;

endpackage

`default_nettype wire

>>> design/mpbp_in_if.sv
// ----------------------------------------------------------------------------
// MQTT parser input channel
// Valid/ready channel that carries one raw stream byte per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpbp_in_if import mpbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> design/mpbp_out_if.sv
// ----------------------------------------------------------------------------
// MQTT parser result channel
// Valid/ready channel that carries one tagged byte result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpbp_out_if import mpbp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROLE_W-1:0]  byte_role;
    logic [VALUE_W-1:0] field_value;
    logic [TYPE_W-1:0]  packet_type;
    logic [QOS_W-1:0]   qos_level;
    logic               dup_flag;
    logic               retain_flag;
    logic               end_of_packet;
    logic [ERR_W-1:0]   error_code;

    modport source (
        output valid, output byte_role, output field_value, output packet_type,
        output qos_level, output dup_flag, output retain_flag,
        output end_of_packet, output error_code, input ready
    );
    modport sink (
        input valid, input byte_role, input field_value, input packet_type,
        input qos_level, input dup_flag, input retain_flag,
        input end_of_packet, input error_code, output ready
    );
endinterface

`default_nettype wire

>>> design/mqtt_packet_byte_parser_core.sv
// ----------------------------------------------------------------------------
// MQTT packet byte parser
// Tags each byte of an MQTT 3.1.1 stream with its role and decodes the
// fixed header, remaining length and the CONNECT, PUBLISH, SUBSCRIBE and
// UNSUBSCRIBE body fields.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload                         Per transfer
//   i_in      in          in_byte                         one stream byte
//   o_out     out         role, value, header, eop, err   one result
//
// Each byte is parsed in the cycle it is accepted and its result sits in the
// output register from the next cycle on: one byte per cycle while the sink
// keeps up. The parse state update is the only loop.
// A new byte is taken whenever the output register is empty or being drained,
// so a stalled sink stops input only while its result is held.
// Reset clears the parse state and the output valid; no clearing pass is needed.
// After a bad length encoding the parser stays halted until reset.
`timescale 1ns / 1ps
`default_nettype none
`include "mqtt_packet_byte_parser_core_macros.svh"

module mqtt_packet_byte_parser_core import mpbp_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mpbp_in_if.sink       i_in,
    mpbp_out_if.source    o_out
);

    // Parse state.
    t_phase               r_phase, n_phase;
    logic [VALUE_W-1:0]   r_left, n_left;
    logic [LBC_W-1:0]     r_lbc, n_lbc;
    logic [TYPE_W-1:0]    r_type, n_type;
    logic [3:0]           r_flags, n_flags;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [BYTE_W-1:0]    r_high, n_high;
    logic                 r_halted, n_halted;

    // Result register.
    logic                 r_out_valid;
    logic [ROLE_W-1:0]    r_role, n_role;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic                 r_eop, n_eop;
    logic [ERR_W-1:0]     r_err, n_err;
    logic [TYPE_W-1:0]    r_out_type;
    logic [3:0]           r_out_flags;

    logic                 in_xfer;
    logic [BYTE_W-1:0]    in_b;
    logic [VALUE_W-1:0]   acc;
    logic [VALUE_W-1:0]   rem;
    logic [COUNT_W-1:0]   word;
    logic [COUNT_W-1:0]   count_dec;
    logic [VALUE_W:0]     rem_ext;
    logic [VALUE_W:0]     word_ext;
    logic                 qos_nz;
    t_phase               next;

    function automatic t_phase start_phase(input logic [TYPE_W-1:0] ptype);
        t_phase ph;
        case (ptype)
            TYPE_CONNECT:     ph = PH_C_NLEN_H;
            TYPE_PUBLISH:     ph = PH_P_TLEN_H;
            TYPE_SUBSCRIBE:   ph = PH_S_ID_H;
            TYPE_UNSUBSCRIBE: ph = PH_S_ID_H;
            default:          ph = PH_OPAQUE;
        endcase
        return ph;
    endfunction

    function automatic logic end_ok(input t_phase ph);
        return (ph == PH_SKIP) || (ph == PH_OPAQUE) || (ph == PH_P_PAY) ||
               (ph == PH_S_TLEN_H);
    endfunction

    // Input handshake: take a byte whenever the result register can move.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign in_b       = i_in.in_byte;

    // Shared datapath terms.
    assign acc       = r_left | (VALUE_W'(in_b[6:0]) << (5'd7 * 5'(r_lbc)));
    assign rem       = (r_left != '0) ? (r_left - VALUE_W'(1)) : '0;
    assign word      = {r_high, in_b};
    assign count_dec = r_count - COUNT_W'(1);
    assign rem_ext   = {1'b0, rem};
    assign word_ext  = (VALUE_W+1)'(word);
    assign qos_nz    = (r_flags[2:1] != 2'b00);

    // Next state and result for the byte on the input.
    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_lbc    = r_lbc;
        n_type   = r_type;
        n_flags  = r_flags;
        n_count  = r_count;
        n_high   = r_high;
        n_halted = r_halted;
        n_role   = ROLE_SKIPPED;
        n_value  = '0;
        n_eop    = 1'b0;
        n_err    = ERR_NONE;
        next     = r_phase;

        if (r_halted) begin
            n_err = ERR_BAD_LEN;
        end else if (r_phase == PH_HDR) begin
            n_role  = ROLE_HEADER;
            n_value = VALUE_W'(in_b);
            n_type  = in_b[7:4];
            n_flags = in_b[3:0];
            n_left  = '0;
            n_lbc   = '0;
            n_phase = PH_LEN;
        end else if (r_phase == PH_LEN) begin
            n_value = acc;
            if (in_b[7]) begin
                n_role = ROLE_LEN_BYTE;
                if ((3'(r_lbc) + 3'd1) >= 3'(MAX_LENGTH_BYTES)) begin
                    n_err    = ERR_BAD_LEN;
                    n_halted = 1'b1;
                end else begin
                    n_lbc  = r_lbc + LBC_W'(1);
                    n_left = acc;
                end
            end else begin
                n_role = ROLE_LEN_DONE;
                n_lbc  = '0;
                n_left = acc;
                next   = start_phase(r_type);
                if (acc == '0) begin
                    n_eop   = 1'b1;
                    n_phase = PH_HDR;
                    if (!end_ok(next)) begin
                        n_err = ERR_TRUNCATED;
                    end
                end else begin
                    n_phase = next;
                end
            end
        end else begin
            n_value = VALUE_W'(in_b);
            case (r_phase)
                PH_OPAQUE: begin
                    n_role = ROLE_OPAQUE;
                end
                PH_C_NLEN_H, PH_C_KA_H, PH_C_IDLEN_H, PH_P_TLEN_H, PH_P_ID_H,
                PH_S_ID_H, PH_S_TLEN_H: begin
                    n_role = ROLE_HIGH_HALF;
                    n_high = in_b;
                    case (r_phase)
                        PH_C_NLEN_H:  next = PH_C_NLEN_L;
                        PH_C_KA_H:    next = PH_C_KA_L;
                        PH_C_IDLEN_H: next = PH_C_IDLEN_L;
                        PH_P_TLEN_H:  next = PH_P_TLEN_L;
                        PH_P_ID_H:    next = PH_P_ID_L;
                        PH_S_ID_H:    next = PH_S_ID_L;
                        default:      next = PH_S_TLEN_L;
                    endcase
                end
                PH_C_NLEN_L: begin
                    n_role  = ROLE_NAME_LEN;
                    n_value = VALUE_W'(word);
                    n_count = word;
                    if ((word_ext + (VALUE_W+1)'(6)) > rem_ext) begin
                        n_err = ERR_TRUNCATED;
                        next  = PH_SKIP;
                    end else begin
                        next = (word != '0) ? PH_C_NAME : PH_C_VER;
                    end
                end
                PH_C_NAME: begin
                    n_role  = ROLE_NAME_BYTE;
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        next = PH_C_VER;
                    end
                end
                PH_C_VER: begin
                    n_role = ROLE_VERSION;
                    next   = PH_C_FLAGS;
                end
                PH_C_FLAGS: begin
                    n_role = ROLE_CON_FLAGS;
                    next   = PH_C_KA_H;
                end
                PH_C_KA_L: begin
                    n_role  = ROLE_KEEPALIVE;
                    n_value = VALUE_W'(word);
                    next    = PH_C_IDLEN_H;
                end
                PH_C_IDLEN_L: begin
                    n_role  = ROLE_ID_LEN;
                    n_value = VALUE_W'(word);
                    n_count = word;
                    if (VALUE_W'(word) != rem) begin
                        n_err = ERR_CON_LEN;
                        next  = PH_SKIP;
                    end else begin
                        next = (word != '0) ? PH_C_ID : PH_SKIP;
                    end
                end
                PH_C_ID: begin
                    n_role  = ROLE_ID_BYTE;
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        next = PH_SKIP;
                    end
                end
                PH_P_TLEN_L: begin
                    n_role  = ROLE_NAME_LEN;
                    n_value = VALUE_W'(word);
                    n_count = word;
                    if ((word_ext + (qos_nz ? (VALUE_W+1)'(2) : '0)) > rem_ext) begin
                        n_err = ERR_TRUNCATED;
                        next  = PH_SKIP;
                    end else if (word != '0) begin
                        next = PH_P_TOPIC;
                    end else begin
                        next = qos_nz ? PH_P_ID_H : PH_P_PAY;
                    end
                end
                PH_P_TOPIC: begin
                    n_role  = ROLE_NAME_BYTE;
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        next = qos_nz ? PH_P_ID_H : PH_P_PAY;
                    end
                end
                PH_P_ID_L: begin
                    n_role  = ROLE_PACKET_ID;
                    n_value = VALUE_W'(word);
                    next    = PH_P_PAY;
                end
                PH_P_PAY: begin
                    n_role = ROLE_PAYLOAD;
                end
                PH_S_ID_L: begin
                    n_role  = ROLE_PACKET_ID;
                    n_value = VALUE_W'(word);
                    next    = PH_S_TLEN_H;
                end
                PH_S_TLEN_L: begin
                    n_role  = ROLE_NAME_LEN;
                    n_value = VALUE_W'(word);
                    n_count = word;
                    if ((word_ext + ((r_type == TYPE_SUBSCRIBE) ? (VALUE_W+1)'(1) : '0))
                            > rem_ext) begin
                        n_err = ERR_TRUNCATED;
                        next  = PH_SKIP;
                    end else if (word != '0) begin
                        next = PH_S_TOPIC;
                    end else begin
                        next = (r_type == TYPE_SUBSCRIBE) ? PH_S_QOS : PH_S_TLEN_H;
                    end
                end
                PH_S_TOPIC: begin
                    n_role  = ROLE_NAME_BYTE;
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        next = (r_type == TYPE_SUBSCRIBE) ? PH_S_QOS : PH_S_TLEN_H;
                    end
                end
                PH_S_QOS: begin
                    n_role = ROLE_SUB_QOS;
                    next   = PH_S_TLEN_H;
                end
                default: begin
                    // Skipping the rest of a faulty packet.
                    n_role  = ROLE_SKIPPED;
                    n_value = '0;
                    next    = PH_SKIP;
                end
            endcase

            // Packet end is set by the remaining length running out.
            if (rem == '0) begin
                n_eop   = 1'b1;
                n_phase = PH_HDR;
                n_left  = '0;
                if ((n_err == ERR_NONE) && !end_ok(next)) begin
                    n_err = ERR_TRUNCATED;
                end
            end else begin
                n_phase = next;
                n_left  = rem;
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR;
            r_left   <= '0;
            r_lbc    <= '0;
            r_type   <= '0;
            r_flags  <= '0;
            r_count  <= '0;
            r_high   <= '0;
            r_halted <= 1'b0;
        end else if (in_xfer) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_lbc    <= n_lbc;
            r_type   <= n_type;
            r_flags  <= n_flags;
            r_count  <= n_count;
            r_high   <= n_high;
            r_halted <= n_halted;
        end
    end

    // Result register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_role      <= n_role;
            r_value     <= n_value;
            r_eop       <= n_eop;
            r_err       <= n_err;
            r_out_type  <= n_type;
            r_out_flags <= n_flags;
        end
    end

    // Output port drive.
    assign o_out.valid         = r_out_valid;
    assign o_out.byte_role     = r_role;
    assign o_out.field_value   = r_value;
    assign o_out.packet_type   = r_out_type;
    assign o_out.qos_level     = r_out_flags[2:1];
    assign o_out.dup_flag      = r_out_flags[3];
    assign o_out.retain_flag   = r_out_flags[0];
    assign o_out.end_of_packet = r_eop;
    assign o_out.error_code    = r_err;

    // Checks.
    `MPBP_ASSERT_NEXT(a_halt_sticks, r_halted, r_halted, "parser left the halted state")
    `MPBP_ASSERT(a_bad_len_halts, !(r_out_valid && (r_err == ERR_BAD_LEN)) || r_halted, "length error without halt")
    `MPBP_ASSERT_NEXT(a_eop_to_header, in_xfer && n_eop, r_phase == PH_HDR, "packet end did not return to header")
    `MPBP_ASSERT(a_lbc_range, 3'(r_lbc) < 3'(MAX_LENGTH_BYTES), "length byte count out of range")

endmodule

`default_nettype wire
